// File: rtl/core/sdff_pkg.sv
package sdff_pkg;

  // Fixed field widths of the input and result items.
  localparam int VALUE_W = 64;
  localparam int FIELD_W = 6;
  localparam int SIZE_W  = 3;
  localparam int CHAR_W  = 8;

  // Decimal conversion: enough BCD digits for any 64-bit magnitude.
  localparam int DIGITS  = 20;
  localparam int DIG_W   = $clog2(DIGITS);
  localparam int ND_W    = $clog2(DIGITS + 1);
  localparam int STEP_W  = $clog2(VALUE_W);

  // Size codes; unused codes behave as a 32-bit int.
  localparam logic [SIZE_W-1:0] SZ_INT32 = 3'd0;
  localparam logic [SIZE_W-1:0] SZ_INT8  = 3'd1;
  localparam logic [SIZE_W-1:0] SZ_INT16 = 3'd2;
  localparam logic [SIZE_W-1:0] SZ_LONG  = 3'd3;
  localparam logic [SIZE_W-1:0] SZ_LLONG = 3'd4;

  // Characters of the formatted field.
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_PLAN,
    ST_LAYOUT,
    ST_EMIT
  } sdff_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv_step;
    logic count;
    logic plan;
    logic layout;
    logic emit;
  } sdff_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic len_zero;
    logic emit_last;
    logic out_free;
  } sdff_sts_t;

endpackage

// File: rtl/core/sdff_ctrl.sv
module sdff_ctrl
  import sdff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sdff_sts_t sts,
  output sdff_cmd_t cmd
);

  sdff_state_t state_r;
  sdff_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_done) state_nxt = ST_COUNT;
      end
      ST_COUNT:  state_nxt = ST_PLAN;
      ST_PLAN:   state_nxt = ST_LAYOUT;
      ST_LAYOUT: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.len_zero) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free && sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV:   cmd.conv_step = 1'b1;
      ST_COUNT:  cmd.count     = 1'b1;
      ST_PLAN:   cmd.plan      = 1'b1;
      ST_LAYOUT: cmd.layout    = 1'b1;
      ST_EMIT:   cmd.emit      = sts.out_free && !sts.len_zero;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // The final conversion step always hands over to the digit count.
  a_conv_to_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && sts.conv_done) |=> state_r == ST_COUNT)
    else $error("conversion did not hand over to digit count");

  // An item taken in idle starts the conversion on the next cycle.
  a_load_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> state_r == ST_CONV)
    else $error("accepted item did not start conversion");
`endif

endmodule

// File: rtl/core/sdff_dp.sv
module sdff_dp
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdff_cmd_t           cmd,
  output sdff_sts_t           sts,
  input  logic [VALUE_W-1:0]  value,
  input  logic [SIZE_W-1:0]   size_code,
  input  logic [FIELD_W-1:0]  field_width,
  input  logic [FIELD_W-1:0]  precision,
  input  logic                has_precision,
  input  logic                left_justify,
  input  logic                zero_pad,
  input  logic                plus_sign,
  input  logic                space_sign,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [CHAR_W-1:0]   out_char,
  output logic                out_last
);

  localparam int LEN_W = $clog2(MAX_FIELD + 2);

  // Captured item.
  logic [VALUE_W-1:0] mag_r;
  logic               neg_r;
  logic [LEN_W-1:0]   width_r;
  logic [LEN_W-1:0]   prec_r;
  logic               hasp_r;
  logic               left_r;
  logic               zero_r;
  logic               plus_r;
  logic               space_r;

  // Conversion and layout.
  logic [STEP_W-1:0]  step_r;
  logic [3:0]         bcd_r [DIGITS];
  logic [ND_W-1:0]    nd_r;
  logic               has_sign_r;
  logic [CHAR_W-1:0]  sign_ch_r;
  logic [LEN_W-1:0]   zeros_r;
  logic [LEN_W-1:0]   body_r;
  logic [LEN_W-1:0]   b1_r;
  logic [LEN_W-1:0]   b2_r;
  logic [LEN_W-1:0]   b3_r;
  logic [LEN_W-1:0]   b4_r;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   pos_r;

  // Result register.
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  // Combinational helpers.
  logic [VALUE_W-1:0] sext_c;
  logic [LEN_W-1:0]   width_c;
  logic [LEN_W-1:0]   prec_c;
  logic [3:0]         adj_c [DIGITS];
  logic [3:0]         bcd_c [DIGITS];
  logic [ND_W-1:0]    nd_c;
  logic [LEN_W-1:0]   nd_l;
  logic [LEN_W-1:0]   zeros_c;
  logic [LEN_W-1:0]   pad_c;
  logic               fill_c;
  logic [LEN_W-1:0]   zeros_f;
  logic [LEN_W-1:0]   padl_c;
  logic [LEN_W-1:0]   padr_c;
  logic [LEN_W-1:0]   b2_c;
  logic [LEN_W-1:0]   b3_c;
  logic [LEN_W-1:0]   b4_c;
  logic [LEN_W-1:0]   dig_off;
  logic [DIG_W-1:0]   dig_idx;
  logic [CHAR_W-1:0]  char_c;
  logic               out_free;

  // Sign extension to the selected size.
  always_comb begin
    unique case (size_code)
      SZ_INT8:            sext_c = {{(VALUE_W-8){value[7]}}, value[7:0]};
      SZ_INT16:           sext_c = {{(VALUE_W-16){value[15]}}, value[15:0]};
      SZ_LONG, SZ_LLONG:  sext_c = value;
      default:            sext_c = {{(VALUE_W-32){value[31]}}, value[31:0]};
    endcase
  end

  // Width and precision limited to the largest field.
  always_comb begin
    if (32'(field_width) > 32'(MAX_FIELD)) width_c = LEN_W'(MAX_FIELD);
    else                                   width_c = LEN_W'(field_width);
    if (32'(precision) > 32'(MAX_FIELD))   prec_c  = LEN_W'(MAX_FIELD);
    else                                   prec_c  = LEN_W'(precision);
  end

  // One shift-and-add-3 step of the binary to BCD conversion.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj_c[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    for (int i = 0; i < DIGITS; i++) begin
      if (i == 0) bcd_c[i] = {adj_c[i][2:0], mag_r[VALUE_W-1]};
      else        bcd_c[i] = {adj_c[i][2:0], adj_c[i-1][3]};
    end
  end

  // Digit count: position of the highest nonzero digit, at least one unless the value is 0 with precision 0.
  always_comb begin
    nd_c = ND_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) nd_c = ND_W'(i + 1);
    end
    if (hasp_r && prec_r == '0 && nd_c == ND_W'(1) && bcd_r[0] == 4'd0) begin
      nd_c = '0;
    end
  end

  // Precision zeros.
  assign nd_l    = LEN_W'(nd_r);
  assign zeros_c = (hasp_r && prec_r > nd_l) ? prec_r - nd_l : '0;

  // Padding and segment boundaries of the field.
  always_comb begin
    pad_c   = (width_r > body_r) ? width_r - body_r : '0;
    fill_c  = zero_r && !hasp_r && !left_r;
    zeros_f = fill_c ? zeros_r + pad_c : zeros_r;
    padl_c  = (!left_r && !fill_c) ? pad_c : '0;
    padr_c  = left_r ? pad_c : '0;
    b2_c    = padl_c + LEN_W'(has_sign_r);
    b3_c    = b2_c + zeros_f;
    b4_c    = b3_c + nd_l;
  end

  // Character at the current position.
  assign dig_off = b4_r - LEN_W'(1) - pos_r;
  assign dig_idx = dig_off[DIG_W-1:0];

  always_comb begin
    if (pos_r < b1_r)      char_c = CH_SPACE;
    else if (pos_r < b2_r) char_c = sign_ch_r;
    else if (pos_r < b3_r) char_c = CH_ZERO;
    else if (pos_r < b4_r) char_c = CH_ZERO | {4'd0, bcd_r[dig_idx]};
    else                   char_c = CH_SPACE;
  end

  // Capture, conversion and layout registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r   <= sext_c[VALUE_W-1] ? VALUE_W'(0) - sext_c : sext_c;
      neg_r   <= sext_c[VALUE_W-1];
      width_r <= width_c;
      prec_r  <= prec_c;
      hasp_r  <= has_precision;
      left_r  <= left_justify;
      zero_r  <= zero_pad;
      plus_r  <= plus_sign;
      space_r <= space_sign;
      step_r  <= '0;
      for (int i = 0; i < DIGITS; i++) bcd_r[i] <= 4'd0;
    end
    if (cmd.conv_step) begin
      mag_r  <= {mag_r[VALUE_W-2:0], 1'b0};
      step_r <= step_r + STEP_W'(1);
      for (int i = 0; i < DIGITS; i++) bcd_r[i] <= bcd_c[i];
    end
    if (cmd.count) begin
      nd_r <= nd_c;
    end
    if (cmd.plan) begin
      has_sign_r <= neg_r || plus_r || space_r;
      sign_ch_r  <= neg_r ? CH_MINUS : (plus_r ? CH_PLUS : CH_SPACE);
      zeros_r    <= zeros_c;
      body_r     <= zeros_c + nd_l + LEN_W'(neg_r || plus_r || space_r);
    end
    if (cmd.layout) begin
      b1_r  <= padl_c;
      b2_r  <= b2_c;
      b3_r  <= b3_c;
      b4_r  <= b4_c;
      len_r <= b4_c + padr_c;
      pos_r <= '0;
    end
    if (cmd.emit) begin
      pos_r <= pos_r + LEN_W'(1);
    end
  end

  // Result register: a new beat loads when the old one is gone or leaving.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r <= char_c;
      out_last_r <= sts.emit_last;
    end
  end

  // Status toward the controller.
  assign sts.conv_done = (step_r == STEP_W'(VALUE_W - 1));
  assign sts.len_zero  = (len_r == '0);
  assign sts.emit_last = (pos_r == len_r - LEN_W'(1));
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/core/signed_decimal_field_formatter.sv
// Formats one signed integer as the text of a printf %d conversion.
// Input channel (in_*): one beat carries the value, its size code and the
// format: field width, precision, has-precision and the -, 0, + and space
// flags. Result channel (out_*): one ASCII character per beat, with
// out_tlast on the final character of the field. An empty field (value 0
// with precision 0, no sign and no width) produces no beat at all.
// Operation: after the input beat, a serial shift-and-add-3 conversion
// to BCD, then digit count and field layout, then one character per
// cycle while the receiver is ready. A field holds 0 to MAX_FIELD + 1
// characters.
// One item is worked on at a time; in_tready is high only when the block
// is idle, which may be while the last character still waits in the
// output register. When the receiver stalls, the character in the output
// register holds and character generation pauses.
// Reset (rst_n low, synchronous) returns the block to idle and drops
// out_tvalid; any field in progress is discarded.
module signed_decimal_field_formatter
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  // value[63:0], field_width[69:64], precision[75:70], has_precision[76],
  // left_justify[77], zero_pad[78], plus_sign[79], space_sign[80], zero[87:81]
  input  logic [87:0] in_tdata,
  // size_code[2:0]
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_char[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready
);

  sdff_cmd_t cmd;
  sdff_sts_t sts;

  // Sequencing of conversion, layout and character emission.
  sdff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Magnitude, BCD conversion, field layout and output register.
  sdff_dp #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .value         (in_tdata[63:0]),
    .size_code     (in_tuser),
    .field_width   (in_tdata[69:64]),
    .precision     (in_tdata[75:70]),
    .has_precision (in_tdata[76]),
    .left_justify  (in_tdata[77]),
    .zero_pad      (in_tdata[78]),
    .plus_sign     (in_tdata[79]),
    .space_sign    (in_tdata[80]),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_char      (out_tdata),
    .out_last      (out_tlast)
  );

`ifndef SYNTHESIS
  // Only one item is in flight: accepting a beat closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // Every character is a space, a sign or a decimal digit.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == CH_SPACE || out_tdata == CH_PLUS ||
                    out_tdata == CH_MINUS ||
                    (out_tdata >= CH_ZERO && out_tdata <= CH_NINE)))
    else $error("character outside the %%d character set");
`endif

endmodule
